// ===== src/tsc_pkg.sv =====
// Types and constants shared by the thumb shifter with carry unit.
`default_nettype none

package tsc_pkg;

  // Command codes
  localparam logic [1:0] CMD_IMM = 2'd0;  // immediate shift (imm5 decode)
  localparam logic [1:0] CMD_REG = 2'd1;  // register shift (amount byte)
  localparam logic [1:0] CMD_IMX = 2'd2;  // Thumb modified immediate expansion

  // Shift type codes
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // Carry source codes
  localparam logic [1:0] CY_FIX = 2'd0;  // carry bit already known
  localparam logic [1:0] CY_IDX = 2'd1;  // pick one bit of the source
  localparam logic [1:0] CY_RES = 2'd2;  // bit 31 of the final result

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [1:0]  shift_type;
    logic [7:0]  shift_amount;
    logic [11:0] imm12;
    logic        cflag;
  } req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        carry;
    logic        unpredictable;
  } rsp_t;

  // Decoded operation, held after the first stage
  typedef struct packed {
    logic [31:0] src;
    logic [4:0]  rot;    // rotate right amount
    logic [5:0]  cnt;    // bits replaced by fill, 0..32
    logic        left;   // replaced bits at the low end
    logic        fill;
    logic [1:0]  cmode;
    logic        cbit;
    logic [4:0]  cidx;
    logic        unp;
  } s1_t;

  // Rotated value and replacement mask, held after the second stage
  typedef struct packed {
    logic [31:0] rotated;
    logic [31:0] mask;
    logic        fill;
    logic        cres;
    logic        cbit;
    logic        unp;
  } s2_t;

endpackage

`default_nettype wire

// ===== src/thumb_shifter_with_carry_unit.sv =====
// Top level of the thumb shifter with carry unit: a three-stage operand shifter.
//
// Usage:
//   Request channel (req, req_valid, req_stall): one transfer carries a command,
//   a 32-bit value, shift type, shift amount, 12-bit immediate and the C flag.
//   Response channel (rsp, rsp_valid, rsp_stall): one transfer per request with
//   the result, the carry-out and the unpredictable flag, in request order.
//   A request passes the stage 1, stage 2 and output registers in order, and
//   rsp_valid is the output register's valid bit. Throughput is one transfer per
//   cycle while the response is not stalled: stage 1 decodes the command, stage 2
//   does the 32-bit rotate and builds the fill mask, stage 3 merges and registers.
//   When the receiver stalls a valid response, the whole pipe holds and
//   req_stall rises in the same cycle; nothing is dropped or repeated, and
//   bubbles in the pipe are kept while it holds.
//   Reset (rst, synchronous) clears every stage's valid bit; the payload
//   registers are left as they are.
`default_nettype none

module thumb_shifter_with_carry_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  output logic               req_stall,
  input  wire tsc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire                rsp_stall,
  output tsc_pkg::rsp_t      rsp
);
  import tsc_pkg::*;

  logic advance;
  logic s1_valid, s2_valid;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  rsp_t rsp_next;

  logic [7:0]  n;
  logic        rrx;
  logic [63:0] rot_wide;
  logic [31:0] pat;
  logic [7:0]  t8;

  // Hold every stage while a finished response is stalled
  assign advance   = !(rsp_valid && rsp_stall);
  assign req_stall = !advance;

  // Stage 1: decode the command into rotate, fill mask count and carry source
  always_comb begin
    n   = 8'd0;
    rrx = 1'b0;
    t8  = req.imm12[7:0];
    pat = {24'd0, t8};
    s1_next       = '0;
    s1_next.src   = req.value;
    s1_next.cmode = CY_FIX;
    s1_next.cbit  = req.cflag;

    if (req.cmd == CMD_IMM) begin
      n = {3'd0, req.shift_amount[4:0]};
      if (req.shift_amount[4:0] == 5'd0) begin
        if (req.shift_type == SH_LSR || req.shift_type == SH_ASR) begin
          n = 8'd32;
        end else if (req.shift_type == SH_ROR) begin
          rrx = 1'b1;
        end
      end
    end else if (req.cmd == CMD_REG) begin
      n = req.shift_amount;
    end

    if (req.cmd == CMD_IMM || req.cmd == CMD_REG) begin
      if (rrx) begin
        // RRX: rotate by one, C flag into bit 31
        s1_next.rot  = 5'd1;
        s1_next.cnt  = 6'd1;
        s1_next.fill = req.cflag;
        s1_next.cbit = req.value[0];
      end else if (n != 8'd0) begin
        case (req.shift_type) inside
          SH_LSL: begin
            s1_next.left = 1'b1;
            if (n < 8'd32) begin
              s1_next.rot   = 5'(6'd32 - {1'b0, n[4:0]});
              s1_next.cnt   = n[5:0];
              s1_next.cmode = CY_IDX;
              s1_next.cidx  = 5'(6'd32 - {1'b0, n[4:0]});
            end else begin
              s1_next.cnt  = 6'd32;
              s1_next.cbit = (n == 8'd32) ? req.value[0] : 1'b0;
            end
          end
          SH_LSR, SH_ASR: begin
            s1_next.fill = (req.shift_type == SH_ASR) ? req.value[31] : 1'b0;
            if (n < 8'd32) begin
              s1_next.rot   = n[4:0];
              s1_next.cnt   = n[5:0];
              s1_next.cmode = CY_IDX;
              s1_next.cidx  = n[4:0] - 5'd1;
            end else begin
              s1_next.cnt = 6'd32;
              if (req.shift_type == SH_ASR) begin
                s1_next.cbit = req.value[31];
              end else begin
                s1_next.cbit = (n == 8'd32) ? req.value[31] : 1'b0;
              end
            end
          end
          default: begin
            // ROR: carry is the top bit of the rotated value
            s1_next.rot   = n[4:0];
            s1_next.cmode = CY_RES;
          end
        endcase
      end
    end else if (req.cmd == CMD_IMX) begin
      if (req.imm12[11:10] == 2'd0) begin
        case (req.imm12[9:8])
          2'd0:    pat = {24'd0, t8};
          2'd1:    pat = {8'd0, t8, 8'd0, t8};
          2'd2:    pat = {t8, 8'd0, t8, 8'd0};
          default: pat = {t8, t8, t8, t8};
        endcase
        s1_next.src = pat;
        s1_next.unp = (req.imm12[9:8] != 2'd0) && (t8 == 8'd0);
      end else begin
        s1_next.src   = {24'd0, 1'b1, req.imm12[6:0]};
        s1_next.rot   = req.imm12[11:7];
        s1_next.cmode = CY_RES;
      end
    end
  end

  // Stage 2: rotate right, build the fill mask, pick an indexed carry
  always_comb begin
    rot_wide        = {s1.src, s1.src} >> s1.rot;
    s2_next.rotated = rot_wide[31:0];
    s2_next.mask    = s1.left ? ~(32'hFFFF_FFFF << s1.cnt) : ~(32'hFFFF_FFFF >> s1.cnt);
    s2_next.fill    = s1.fill;
    s2_next.cres    = (s1.cmode == CY_RES);
    s2_next.cbit    = (s1.cmode == CY_IDX) ? s1.src[s1.cidx] : s1.cbit;
    s2_next.unp     = s1.unp;
  end

  // Stage 3: merge fill into the masked bits, resolve carry
  always_comb begin
    rsp_next.result        = (s2.rotated & ~s2.mask) | ({32{s2.fill}} & s2.mask);
    rsp_next.carry         = s2.cres ? rsp_next.result[31] : s2.cbit;
    rsp_next.unpredictable = s2.unp;
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= req_valid;
      s2_valid  <= s1_valid;
      rsp_valid <= s2_valid;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      s1  <= s1_next;
      s2  <= s2_next;
      rsp <= rsp_next;
    end
  end

  // A transfer in reaches stage 1 on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> s1_valid)
    else $error("accepted request did not enter stage 1");

  // Stage 1 moves to stage 2 whenever the pipe advances
  a_s2: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !req_stall) |=> s2_valid)
    else $error("stage 1 item lost on advance");

  // Stage 2 moves to the output whenever the pipe advances
  a_out: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !req_stall) |=> rsp_valid)
    else $error("stage 2 item lost on advance");

  // Requests are held back only behind a stalled response
  a_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without a held response");

endmodule

`default_nettype wire
